[hdl/tlar_pkg.sv]
package tlar_pkg;

    // fixed register file layout
    localparam int SIZE_REGS  = 4;
    localparam int SIZE_W     = 13;
    localparam int SIZE_SEL_W = 2;
    localparam int NDIM_W     = 3;
    localparam int IDX_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // parameter defaults
    localparam int DEF_MAX_DIMS  = 4;
    localparam int DEF_DIM_BITS  = 12;
    localparam int DEF_DATA_BITS = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION = 3'd0,
        REG_NUM_DIMS  = 3'd1,
        REG_DIM0_SIZE = 3'd2,
        REG_DIM1_SIZE = 3'd3,
        REG_DIM2_SIZE = 3'd4,
        REG_DIM3_SIZE = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        DIR_ROW_TO_COL = 1'b0,
        DIR_COL_TO_ROW = 1'b1
    } remap_dir_t;

    // control shared by the counter and the weight chain
    typedef struct packed {
        remap_dir_t          direction;
        logic [NDIM_W-1:0]   n_dims;
    } remap_ctl_t;

endpackage

[hdl/tlar_digit_ctr.sv]
module tlar_digit_ctr
    import tlar_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DIM_BITS = DEF_DIM_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  remap_ctl_t                           ctl,
    input  logic [MAX_DIMS-1:0][DIM_BITS:0]      ext,
    input  logic                                 step,
    output logic [MAX_DIMS-1:0][DIM_BITS-1:0]    digit,
    output logic                                 last
);

    logic [MAX_DIMS-1:0][DIM_BITS-1:0] digit_reg;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] digit_next;
    logic [MAX_DIMS-1:0][DIM_BITS:0]   inc;
    logic [MAX_DIMS-1:0]               act;
    logic [MAX_DIMS-1:0]               full;
    logic [MAX_DIMS-1:0]               fullx;
    logic [MAX_DIMS-1:0]               cin;

    always_comb
    begin
        logic run;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            act[k]   = NDIM_W'(k) < ctl.n_dims;
            digit[k] = act[k] ? digit_reg[k] : '0;
            inc[k]   = {1'b0, digit_reg[k]} + (DIM_BITS+1)'(1);
            full[k]  = inc[k] >= ext[k];
            fullx[k] = full[k] || !act[k];
        end
        last = &fullx;

        // carry enters from the fastest digit
        run = 1'b1;
        if (ctl.direction == DIR_ROW_TO_COL)
        begin
            for (int k = MAX_DIMS - 1; k >= 0; k--)
            begin
                cin[k] = run;
                run    = run && fullx[k];
            end
        end
        else
        begin
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                cin[k] = run;
                run    = run && fullx[k];
            end
        end

        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (!act[k])
                digit_next[k] = '0;
            else if (cin[k] && full[k])
                digit_next[k] = '0;
            else if (cin[k])
                digit_next[k] = inc[k][DIM_BITS-1:0];
            else
                digit_next[k] = digit_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digit_reg <= '0;
        else if (step)
            digit_reg <= digit_next;
    end

endmodule

[hdl/tlar_weights.sv]
module tlar_weights
    import tlar_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DIM_BITS = DEF_DIM_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  remap_ctl_t                        ctl,
    input  logic [MAX_DIMS-1:0][DIM_BITS:0]   ext,
    input  logic                              cfg_we,
    output logic [MAX_DIMS-1:0][IDX_W-1:0]    weight,
    output logic                              settled
);

    localparam int EW    = DIM_BITS + 1;
    localparam int PW    = IDX_W + EW;
    localparam int SET_W = $clog2(MAX_DIMS + 1);

    logic [MAX_DIMS-1:0][IDX_W-1:0] weight_reg;
    logic [MAX_DIMS-1:0][IDX_W-1:0] weight_next;
    logic [MAX_DIMS-1:0][PW-1:0]    prod;
    logic [SET_W-1:0]               settle_reg;
    logic [SET_W-1:0]               settle_next;

    // position p holds the p-th fastest dimension of the destination
    always_comb
    begin
        int d;
        prod           = '0;
        weight_next[0] = IDX_W'(1);
        for (int p = 1; p < MAX_DIMS; p++)
        begin
            d = (ctl.direction == DIR_ROW_TO_COL) ? (p - 1) : (MAX_DIMS - p);
            prod[p]        = PW'(weight_reg[p-1]) * PW'(ext[d]);
            weight_next[p] = prod[p][IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
    end

    always_comb
    begin
        if (cfg_we)
            settle_next = SET_W'(MAX_DIMS);
        else if (settle_reg != '0)
            settle_next = settle_reg - SET_W'(1);
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SET_W'(MAX_DIMS);
        else
            settle_reg <= settle_next;
    end

    assign weight  = weight_reg;
    assign settled = (settle_reg == '0);

endmodule

[hdl/tensor_layout_address_remap_top.sv]
// row-major / column-major transpose address generator
// input channel (in_valid/in_ready) takes one element per item in source order;
// output channel (out_valid/out_ready) gives the element's destination index,
// the element bits unchanged and a flag on the final element of the array
// a mixed-radix counter walks the source multi-index and wraps after the last
// element; the destination index is a dot product of the digits with stride
// weights built by a registered multiply chain from the configured extents
// an accepted element passes the input, product and sum registers before
// out_valid rises; one item per cycle while out_ready stays high and the weight
// chain is settled, set by the counter update and the fully pipelined product
// and sum stages
// after reset and after every cfg_we write, in_ready stays low while the
// weight chain settles; configuration writes are always taken
// reset restores direction 0, one dimension and all extents 1, clears the
// counter and empties the pipeline
// when the receiver stalls, each stage holds its item; bubbles still close up,
// so up to three items wait in the block before in_ready drops
module tensor_layout_address_remap_top
    import tlar_pkg::*;
#(
    parameter int MAX_DIMS  = DEF_MAX_DIMS,
    parameter int DIM_BITS  = DEF_DIM_BITS,
    parameter int DATA_BITS = DEF_DATA_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // element input
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DATA_BITS-1:0]   element_value,
    // address output
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [IDX_W-1:0]       dest_index,
    output logic [DATA_BITS-1:0]   moved_value,
    output logic                   last_element
);

    localparam int EW   = DIM_BITS + 1;
    localparam int SW   = (SIZE_W > EW) ? SIZE_W : EW;
    localparam int NLIM = (MAX_DIMS < SIZE_REGS) ? MAX_DIMS : SIZE_REGS;
    localparam int PW   = IDX_W + DIM_BITS;
    localparam logic [SW-1:0] EXT_CAP = SW'(1) << DIM_BITS;

    // configuration registers
    remap_dir_t                          direction_reg;
    logic [NDIM_W-1:0]                   num_dims_reg;
    logic [SIZE_REGS-1:0][SIZE_W-1:0]    size_reg;
    logic [SIZE_SEL_W-1:0]               size_sel;

    remap_ctl_t                          ctl;
    logic [MAX_DIMS-1:0][EW-1:0]         ext;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]   digit;
    logic                                last;
    logic [MAX_DIMS-1:0][IDX_W-1:0]      weight;
    logic                                settled;

    // pipeline
    logic                                en1;
    logic                                en2;
    logic                                en3;
    logic                                accept;

    logic                                s1_valid_reg;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]   s1_digit_reg;
    logic [DATA_BITS-1:0]                s1_value_reg;
    logic                                s1_last_reg;

    logic                                s2_valid_reg;
    logic [MAX_DIMS-1:0][IDX_W-1:0]      s2_prod_reg;
    logic [MAX_DIMS-1:0][IDX_W-1:0]      s2_prod_next;
    logic [MAX_DIMS-1:0][PW-1:0]         s2_prod_full;
    logic [DATA_BITS-1:0]                s2_value_reg;
    logic                                s2_last_reg;

    logic                                s3_valid_reg;
    logic [IDX_W-1:0]                    s3_dest_reg;
    logic [IDX_W-1:0]                    s3_dest_next;
    logic [DATA_BITS-1:0]                s3_value_reg;
    logic                                s3_last_reg;

    // register writes; unknown indexes are dropped
    assign size_sel = SIZE_SEL_W'(cfg_index - CFG_IDX_W'(REG_DIM0_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ROW_TO_COL;
            num_dims_reg  <= NDIM_W'(1);
            for (int k = 0; k < SIZE_REGS; k++)
                size_reg[k] <= SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index)) inside
                REG_DIRECTION:
                    direction_reg <= remap_dir_t'(cfg_data[0]);
                REG_NUM_DIMS:
                    num_dims_reg <= cfg_data[NDIM_W-1:0];
                REG_DIM0_SIZE, REG_DIM1_SIZE, REG_DIM2_SIZE, REG_DIM3_SIZE:
                    size_reg[size_sel] <= cfg_data[SIZE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // dimension count clamped to 1..NLIM
    always_comb
    begin
        ctl.direction = direction_reg;
        if (num_dims_reg == '0)
            ctl.n_dims = NDIM_W'(1);
        else if (num_dims_reg > NDIM_W'(NLIM))
            ctl.n_dims = NDIM_W'(NLIM);
        else
            ctl.n_dims = num_dims_reg;
    end

    // extents: zero reads as one, oversize saturates, unused dimensions are one
    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_ext
        if (k < SIZE_REGS)
        begin : g_sized
            logic [SW-1:0] sz;
            assign sz = SW'(size_reg[k]);
            always_comb
            begin
                if (NDIM_W'(k) >= ctl.n_dims || sz == '0)
                    ext[k] = EW'(1);
                else if (sz > EXT_CAP)
                    ext[k] = EW'(EXT_CAP);
                else
                    ext[k] = EW'(sz);
            end
        end
        else
        begin : g_unsized
            assign ext[k] = EW'(1);
        end
    end

    tlar_digit_ctr #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_digit_ctr (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .ext   (ext),
        .step  (accept),
        .digit (digit),
        .last  (last)
    );

    tlar_weights #(
        .MAX_DIMS (MAX_DIMS),
        .DIM_BITS (DIM_BITS)
    ) u_weights (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .ext     (ext),
        .cfg_we  (cfg_we),
        .weight  (weight),
        .settled (settled)
    );

    // per-stage advance so bubbles close up under a stall
    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1 && settled;
    assign accept   = in_valid && in_ready;

    // stage 1: digit snapshot and element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_digit_reg <= digit;
            s1_value_reg <= element_value;
            s1_last_reg  <= last;
        end
    end

    // stage 2: digit times stride, digits taken in destination order
    always_comb
    begin
        int d;
        for (int p = 0; p < MAX_DIMS; p++)
        begin
            d = (direction_reg == DIR_ROW_TO_COL) ? p : (MAX_DIMS - 1 - p);
            s2_prod_full[p] = PW'(s1_digit_reg[d]) * PW'(weight[p]);
            s2_prod_next[p] = s2_prod_full[p][IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_prod_reg  <= s2_prod_next;
            s2_value_reg <= s1_value_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // stage 3: sum of the terms, modulo the index width
    always_comb
    begin
        s3_dest_next = '0;
        for (int p = 0; p < MAX_DIMS; p++)
            s3_dest_next = s3_dest_next + s2_prod_reg[p];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_dest_reg  <= s3_dest_next;
            s3_value_reg <= s2_value_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    assign out_valid    = s3_valid_reg;
    assign dest_index   = s3_dest_reg;
    assign moved_value  = s3_value_reg;
    assign last_element = s3_last_reg;

endmodule

[tb/sv/tensor_layout_address_remap_top_tb.sv]
`timescale 1ns / 100ps

module tensor_layout_address_remap_top_tb;
    import tlar_pkg::*;

    // block configuration under test, package defaults
    localparam int MAX_DIMS  = DEF_MAX_DIMS;
    localparam int DIM_BITS  = DEF_DIM_BITS;
    localparam int DATA_BITS = DEF_DATA_BITS;
    localparam int DIM_LIMIT = (MAX_DIMS < SIZE_REGS) ? MAX_DIMS : SIZE_REGS;

    // register indexes past the end of the register file, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // run length and watchdog
    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_FROM  = 1350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 8;

    // one expected address item
    typedef struct {
        logic [IDX_W-1:0]     dest_index;
        logic [DATA_BITS-1:0] moved_value;
        logic                 last_element;
    } remap_result_t;

    // tracks the source multi-index and the register file, predicts the
    // destination address of each accepted element and checks the output
    class remap_scoreboard;
        remap_dir_t            direction;
        logic [NDIM_W-1:0]     dims_reg;
        logic [SIZE_W-1:0]     size_reg [SIZE_REGS];
        logic [DIM_BITS-1:0]   digit [MAX_DIMS];
        remap_result_t         pending_addresses [$];
        int                    mismatches;
        int                    elements;
        int                    array_ends;

        function new();
            direction = DIR_ROW_TO_COL;
            dims_reg  = NDIM_W'(1);
            foreach (size_reg[k])
                size_reg[k] = SIZE_W'(1);
            foreach (digit[k])
                digit[k] = '0;
            mismatches = 0;
            elements   = 0;
            array_ends = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DIRECTION: direction = remap_dir_t'(data[0]);
                REG_NUM_DIMS:  dims_reg  = data[NDIM_W-1:0];
                REG_DIM0_SIZE, REG_DIM1_SIZE, REG_DIM2_SIZE, REG_DIM3_SIZE:
                    size_reg[idx - REG_DIM0_SIZE] = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, anything above the limit saturates
        function int active_dims();
            int n;
            n = dims_reg;
            if (n < 1)
                n = 1;
            if (n > DIM_LIMIT)
                n = DIM_LIMIT;
            return n;
        endfunction

        function longint unsigned extent(int k);
            longint unsigned s;
            s = size_reg[k];
            if (s == 0)
                s = 1;
            if (s > (64'd1 << DIM_BITS))
                s = 64'd1 << DIM_BITS;
            return s;
        endfunction

        // a digit at or past its extent minus one wraps and carries
        function bit bump(int k);
            if (digit[k] + 64'd1 >= extent(k))
            begin
                digit[k] = '0;
                return 1'b1;
            end
            digit[k] = digit[k] + 1'b1;
            return 1'b0;
        endfunction

        function void note_element(logic [DATA_BITS-1:0] value);
            int              n;
            int              k;
            bit              wraps;
            bit              carry;
            longint unsigned acc;
            longint unsigned weight;
            remap_result_t   r;
            n = active_dims();
            for (k = n; k < MAX_DIMS; k++)
                digit[k] = '0;
            wraps = 1'b1;
            for (k = 0; k < n; k++)
                if (digit[k] + 64'd1 < extent(k))
                    wraps = 1'b0;
            acc    = 0;
            weight = 1;
            if (direction == DIR_ROW_TO_COL)
            begin
                for (k = 0; k < n; k++)
                begin
                    acc    += digit[k] * weight;
                    weight *= extent(k);
                end
            end
            else
            begin
                for (k = n - 1; k >= 0; k--)
                begin
                    acc    += digit[k] * weight;
                    weight *= extent(k);
                end
            end
            r.dest_index   = acc[IDX_W-1:0];
            r.moved_value  = value;
            r.last_element = wraps;
            pending_addresses.push_back(r);
            elements++;
            if (wraps)
            begin
                array_ends++;
                foreach (digit[j])
                    digit[j] = '0;
            end
            else if (direction == DIR_ROW_TO_COL)
            begin
                carry = 1'b1;
                for (k = n - 1; k >= 0 && carry; k--)
                    carry = bump(k);
            end
            else
            begin
                carry = 1'b1;
                for (k = 0; k < n && carry; k++)
                    carry = bump(k);
            end
        endfunction

        function void check_result(logic [IDX_W-1:0] got_index,
                                   logic [DATA_BITS-1:0] got_value,
                                   logic got_last);
            remap_result_t want;
            if (pending_addresses.size() == 0)
            begin
                $error("address item with nothing pending: dest_index %0h", got_index);
                mismatches++;
                return;
            end
            want = pending_addresses.pop_front();
            if (got_index !== want.dest_index)
            begin
                $error("dest_index: expected %0h, got %0h", want.dest_index, got_index);
                mismatches++;
            end
            if (got_value !== want.moved_value)
            begin
                $error("moved_value: expected %0h, got %0h", want.moved_value, got_value);
                mismatches++;
            end
            if (got_last !== want.last_element)
            begin
                $error("last_element: expected %0b, got %0b", want.last_element, got_last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_addresses.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [DATA_BITS-1:0]  element_value;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [IDX_W-1:0]      dest_index;
    logic [DATA_BITS-1:0]  moved_value;
    logic                  last_element;

    remap_scoreboard sb = new();

    // random idling on both channels while set
    bit idle_on   = 1'b0;
    // long receiver hold-off, counted down by the receiver process
    int rx_hold   = 0;
    int rx_stall  = 0;
    int sent      = 0;
    int cfg_count = 0;
    int cycles    = 0;

    tensor_layout_address_remap_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dest_index    (dest_index),
        .moved_value   (moved_value),
        .last_element  (last_element)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog, a hang or a lost item ends here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tensor_layout_address_remap_top_tb: FAIL");
            $finish;
        end
    end

    // everything is sampled at the edge, before any nonblocking update lands,
    // so register writes, accepted elements and address items are seen in
    // the same order the block sees them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_element(element_value);
            if (out_valid && out_ready)
                sb.check_result(dest_index, moved_value, last_element);
        end
    end

    // receiver: long hold-off first, then short random stall bursts
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            rx_stall = $urandom_range(0, 3);
        end
        else
            out_ready <= 1'b1;
    end

    // element bits: corners, single set bits and plain random words
    function automatic logic [DATA_BITS-1:0] element_pattern();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {{(DATA_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_BITS - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // offers one element and holds it until taken; valid stays up afterwards
    // so back-to-back items need no second assignment in the same step
    task automatic send_element(input logic [DATA_BITS-1:0] value);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // sender goes quiet until every pending address item has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // every item yields an address item, so an empty queue means idle
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_count++;
        @(posedge clk);
    endtask

    task automatic set_layout(input remap_dir_t dir, input logic [CFG_DATA_W-1:0] dims,
                              input logic [CFG_DATA_W-1:0] s0, input logic [CFG_DATA_W-1:0] s1,
                              input logic [CFG_DATA_W-1:0] s2, input logic [CFG_DATA_W-1:0] s3);
        put_reg(REG_DIRECTION, CFG_DATA_W'(dir));
        put_reg(REG_NUM_DIMS, dims);
        put_reg(REG_DIM0_SIZE, s0);
        put_reg(REG_DIM1_SIZE, s1);
        put_reg(REG_DIM2_SIZE, s2);
        put_reg(REG_DIM3_SIZE, s3);
    endtask

    // random register update between phases; junk in the unused upper bits,
    // mostly small extents so whole arrays fit in a phase, now and then zero,
    // the largest extent, oversize values or a dimension count out of range
    task automatic reconfigure(input bit all_regs);
        logic [CFG_DATA_W-1:0] data;
        int                    k;
        if (all_regs || $urandom_range(0, 3) != 0)
            put_reg(REG_DIRECTION, CFG_DATA_W'($urandom));
        if (all_regs || $urandom_range(0, 3) != 0)
        begin
            data = CFG_DATA_W'($urandom);
            if ($urandom_range(0, 7) == 0)
                data[NDIM_W-1:0] = NDIM_W'($urandom);
            else
                data[NDIM_W-1:0] = NDIM_W'($urandom_range(1, 4));
            put_reg(REG_NUM_DIMS, data);
        end
        for (k = 0; k < SIZE_REGS; k++)
        begin
            if (all_regs || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 15))
                    0:       data = '0;
                    1:       data = CFG_DATA_W'(4096);
                    2:       data = CFG_DATA_W'($urandom_range(4097, 8191));
                    3:       data = CFG_DATA_W'($urandom);
                    default: data = CFG_DATA_W'($urandom_range(1, 4));
                endcase
                put_reg(CFG_IDX_W'(REG_DIM0_SIZE + k), data);
            end
        end
        if ($urandom_range(0, 7) == 0)
            put_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CFG_DATA_W'($urandom));
    endtask

    initial
    begin
        int              phase;
        int              count;
        int              k;
        longint unsigned total;

        // all inputs known from time zero, reset held low at the start
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        element_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        idle_on = 1'b1;

        // reset layout: one dimension of one element, every item is the last
        send_element('0);
        send_element('1);

        // 2x3 row-major source into column-major order, one full array
        set_layout(DIR_ROW_TO_COL, 13'd2, 13'd2, 13'd3, 13'd1, 13'd1);
        repeat (6) send_element(element_pattern());

        // 2x2 column-major source into row-major order
        set_layout(DIR_COL_TO_ROW, 13'd2, 13'd2, 13'd2, 13'd1, 13'd1);
        repeat (4) send_element(element_pattern());

        // dimension count above the limit saturates, zero extents act as one
        set_layout(DIR_ROW_TO_COL, 13'd7, 13'd0, 13'd2, 13'd0, 13'd1);
        repeat (2) send_element(element_pattern());

        // four dimensions at the largest extent, last one written oversize
        set_layout(DIR_ROW_TO_COL, 13'd4, 13'd4096, 13'd4096, 13'd4096, 13'd8191);
        repeat (3) send_element(element_pattern());
        // direction flip mid-array keeps the digits
        put_reg(REG_DIRECTION, CFG_DATA_W'(DIR_COL_TO_ROW));
        repeat (2) send_element(element_pattern());
        // shrinking an extent under a digit makes that digit count as full
        put_reg(REG_DIM3_SIZE, 13'd2);
        repeat (2) send_element(element_pattern());
        // fewer dimensions: the upper digits drop out and are cleared
        put_reg(REG_NUM_DIMS, 13'd2);
        repeat (2) send_element(element_pattern());
        // writes past the register file are dropped, a zero count acts as one
        put_reg(REG_SPARE_LO, '1);
        put_reg(REG_SPARE_HI, '1);
        put_reg(REG_NUM_DIMS, 13'd0);
        repeat (2) send_element(element_pattern());

        // random phases: new layout, then whole arrays where they are small
        // enough, partial ones otherwise so later changes land mid-array
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            idle_on = (sent < QUIET_FROM) && ($urandom_range(0, 5) != 0);
            reconfigure(phase == 0);
            total = 1;
            for (k = 0; k < sb.active_dims(); k++)
                total *= sb.extent(k);
            if (total <= 48 && $urandom_range(0, 3) != 0)
                count = int'(total) * $urandom_range(1, 2);
            else
                count = $urandom_range(1, 40);
            // first phase: receiver holds off long enough to back up the input
            if (phase == 0)
            begin
                rx_hold = 60;
                count   = 24;
            end
            repeat (count) send_element(element_pattern());
            phase++;
        end

        // drain, then idle for the drain tail to catch stray address items
        idle_on = 1'b0;
        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("remap run: %0d elements, %0d array ends, %0d register writes, %0d phases",
                 sb.elements, sb.array_ends, cfg_count, phase);
        $display("both directions, 1 to 4 dims, zero/oversize extents, mid-array changes");
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tensor_layout_address_remap_top_tb: PASS");
        else
            $display("tensor_layout_address_remap_top_tb: FAIL");
        $finish;
    end

endmodule
